// ----- rtl/cau_pkg.sv -----
package cau_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  localparam logic [2:0] CMD_ADD = 3'd0;
  localparam logic [2:0] CMD_SUB = 3'd1;
  localparam logic [2:0] CMD_MUL = 3'd2;
  localparam logic [2:0] CMD_DIV = 3'd3;
  localparam logic [2:0] CMD_EQ  = 3'd4;

  typedef struct packed {
    logic       valid;
    logic [2:0] cmd;
    logic       eq;
    logic       dz;
    logic       ovf;
    logic       neg_re;
    logic       neg_im;
  } cau_ctl_t;

endpackage

// ----- rtl/cau_front.sv -----
module cau_front import cau_pkg::*; #(
  parameter int W  = DATA_WIDTH_DEF,
  parameter int F  = FRAC_BITS_DEF,
  parameter int RW = 3 * W + F + 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [2:0]          cmd,
  input  logic signed [W-1:0] a_re,
  input  logic signed [W-1:0] a_im,
  input  logic signed [W-1:0] b_re,
  input  logic signed [W-1:0] b_im,
  output cau_ctl_t            ctl,
  output logic [W-1:0]        pre_re,
  output logic [W-1:0]        pre_im,
  output logic [RW-1:0]       r_re,
  output logic [RW-1:0]       r_im,
  output logic [2*W-1:0]      d
);

  // {overflow, saturated value}
  function automatic logic [W:0] sat_w(input logic signed [2*W:0] v);
    logic [W+1:0] top;
    top = v[2*W:W-1];
    if ((&top) || !(|top)) begin
      return {1'b0, v[W-1:0]};
    end
    return v[2*W] ? {1'b1, 1'b1, {(W-1){1'b0}}} : {1'b1, 1'b0, {(W-1){1'b1}}};
  endfunction

  // stage A: operands
  logic                va;
  logic [2:0]          cmd_a;
  logic signed [W-1:0] ar, ai, br, bi;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else begin
      va <= in_valid;
    end
    cmd_a <= cmd;
    ar    <= a_re;
    ai    <= a_im;
    br    <= b_re;
    bi    <= b_im;
  end

  // stage B: products, add and subtract
  logic                  vb;
  logic [2:0]            cmd_b;
  logic signed [2*W-1:0] p_rr, p_ii, p_ri, p_ir, p_br, p_bi;
  logic [W-1:0]          as_re_b, as_im_b;
  logic                  as_ovf_b, eq_b;
  logic signed [W:0]     s_re, s_im;
  logic [W:0]            sat_re_a, sat_im_a;

  always_comb begin
    if (cmd_a == CMD_SUB) begin
      s_re = (W+1)'(ar) - (W+1)'(br);
      s_im = (W+1)'(ai) - (W+1)'(bi);
    end else begin
      s_re = (W+1)'(ar) + (W+1)'(br);
      s_im = (W+1)'(ai) + (W+1)'(bi);
    end
    sat_re_a = sat_w((2*W+1)'(s_re));
    sat_im_a = sat_w((2*W+1)'(s_im));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else begin
      vb <= va;
    end
    cmd_b    <= cmd_a;
    p_rr     <= ar * br;
    p_ii     <= ai * bi;
    p_ri     <= ar * bi;
    p_ir     <= ai * br;
    p_br     <= br * br;
    p_bi     <= bi * bi;
    as_re_b  <= sat_re_a[W-1:0];
    as_im_b  <= sat_im_a[W-1:0];
    as_ovf_b <= sat_re_a[W] | sat_im_a[W];
    eq_b     <= (ar == br) && (ai == bi);
  end

  // stage C: sums, product scaling and saturation, divide setup
  logic signed [2*W:0] m_re, m_im, n_re, n_im;
  logic signed [2*W:0] ms_re, ms_im;
  logic [2*W:0]        mag_re, mag_im;
  logic [2*W-1:0]      den;
  logic [W:0]          msat_re, msat_im;
  cau_ctl_t            ctl_next;
  logic [W-1:0]        pre_re_next, pre_im_next;

  always_comb begin
    m_re    = (2*W+1)'(p_rr) - (2*W+1)'(p_ii);
    m_im    = (2*W+1)'(p_ri) + (2*W+1)'(p_ir);
    n_re    = (2*W+1)'(p_rr) + (2*W+1)'(p_ii);
    n_im    = (2*W+1)'(p_ir) - (2*W+1)'(p_ri);
    ms_re   = m_re >>> F;
    ms_im   = m_im >>> F;
    msat_re = sat_w(ms_re);
    msat_im = sat_w(ms_im);
    mag_re  = n_re[2*W] ? $unsigned(-n_re) : $unsigned(n_re);
    mag_im  = n_im[2*W] ? $unsigned(-n_im) : $unsigned(n_im);
    den     = $unsigned(p_br) + $unsigned(p_bi);

    ctl_next        = '0;
    ctl_next.valid  = vb;
    ctl_next.cmd    = cmd_b;
    ctl_next.neg_re = n_re[2*W];
    ctl_next.neg_im = n_im[2*W];
    pre_re_next     = '0;
    pre_im_next     = '0;
    case (cmd_b)
      CMD_ADD, CMD_SUB: begin
        pre_re_next  = as_re_b;
        pre_im_next  = as_im_b;
        ctl_next.ovf = as_ovf_b;
      end
      CMD_MUL: begin
        pre_re_next  = msat_re[W-1:0];
        pre_im_next  = msat_im[W-1:0];
        ctl_next.ovf = msat_re[W] | msat_im[W];
      end
      CMD_DIV: ctl_next.dz = (den == '0);
      CMD_EQ:  ctl_next.eq = eq_b;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else begin
      ctl <= ctl_next;
    end
    pre_re <= pre_re_next;
    pre_im <= pre_im_next;
    r_re   <= RW'(mag_re) << F;
    r_im   <= RW'(mag_im) << F;
    d      <= den;
  end

endmodule

// ----- rtl/cau_div_cell.sv -----
module cau_div_cell import cau_pkg::*; #(
  parameter int W  = DATA_WIDTH_DEF,
  parameter int RW = 3 * W + FRAC_BITS_DEF + 2,
  parameter int K  = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  cau_ctl_t       ctl_in,
  input  logic [W-1:0]   pre_re_in,
  input  logic [W-1:0]   pre_im_in,
  input  logic [RW-1:0]  r_re_in,
  input  logic [RW-1:0]  r_im_in,
  input  logic [W+1:0]   q_re_in,
  input  logic [W+1:0]   q_im_in,
  input  logic [2*W-1:0] d_in,
  output cau_ctl_t       ctl_out,
  output logic [W-1:0]   pre_re_out,
  output logic [W-1:0]   pre_im_out,
  output logic [RW-1:0]  r_re_out,
  output logic [RW-1:0]  r_im_out,
  output logic [W+1:0]   q_re_out,
  output logic [W+1:0]   q_im_out,
  output logic [2*W-1:0] d_out
);

  logic [RW-1:0] dsh;
  logic          ge_re, ge_im;
  logic [W+1:0]  q_re_next, q_im_next;

  // try one quotient bit of weight 2^K in each lane
  always_comb begin
    dsh          = RW'(d_in) << K;
    ge_re        = r_re_in >= dsh;
    ge_im        = r_im_in >= dsh;
    q_re_next    = q_re_in;
    q_im_next    = q_im_in;
    q_re_next[K] = ge_re;
    q_im_next[K] = ge_im;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= ctl_in;
    end
    pre_re_out <= pre_re_in;
    pre_im_out <= pre_im_in;
    d_out      <= d_in;
    r_re_out   <= ge_re ? r_re_in - dsh : r_re_in;
    r_im_out   <= ge_im ? r_im_in - dsh : r_im_in;
    q_re_out   <= q_re_next;
    q_im_out   <= q_im_next;
  end

endmodule

// ----- rtl/complex_arithmetic_unit.sv -----
// Complex arithmetic unit: add, subtract, multiply, divide or compare two
// complex operands in signed fixed point (DATA_WIDTH bits, FRAC_BITS fraction).
// Input channel: cmd and the four operand parts are taken at a rising edge
// with start high; busy is always low, so one item can enter every cycle.
// Output channel: done is high for exactly one cycle with res_re, res_im,
// equal, div_zero and overflow; the receiver cannot stall and takes it then.
// Every command takes the same path through the pipeline, so results leave
// in order. Throughput: one item per cycle.
// The pipeline is a row of DATA_WIDTH + 2 divider cells that each settle one
// quotient bit per cycle for both parts, behind three stages of operand,
// product and sum registers and one output register.
// Reset clears all valid bits; items in flight are dropped and done stays
// low until a new item has passed through.
module complex_arithmetic_unit import cau_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [2:0]                   cmd,
  input  logic signed [DATA_WIDTH-1:0] a_re,
  input  logic signed [DATA_WIDTH-1:0] a_im,
  input  logic signed [DATA_WIDTH-1:0] b_re,
  input  logic signed [DATA_WIDTH-1:0] b_im,
  output logic                         done,
  output logic signed [DATA_WIDTH-1:0] res_re,
  output logic signed [DATA_WIDTH-1:0] res_im,
  output logic                         equal,
  output logic                         div_zero,
  output logic                         overflow
);

  localparam int W  = DATA_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int RW = 3 * W + F + 2;
  localparam int NC = W + 2;

  cau_ctl_t       c_ch   [NC+1];
  logic [W-1:0]   pre_re [NC+1];
  logic [W-1:0]   pre_im [NC+1];
  logic [RW-1:0]  r_re   [NC+1];
  logic [RW-1:0]  r_im   [NC+1];
  logic [W+1:0]   q_re   [NC+1];
  logic [W+1:0]   q_im   [NC+1];
  logic [2*W-1:0] d_ch   [NC+1];

  assign busy = 1'b0;

  cau_front #(.W(W), .F(F), .RW(RW)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start),
    .cmd      (cmd),
    .a_re     (a_re),
    .a_im     (a_im),
    .b_re     (b_re),
    .b_im     (b_im),
    .ctl      (c_ch[0]),
    .pre_re   (pre_re[0]),
    .pre_im   (pre_im[0]),
    .r_re     (r_re[0]),
    .r_im     (r_im[0]),
    .d        (d_ch[0])
  );

  assign q_re[0] = '0;
  assign q_im[0] = '0;

  for (genvar j = 0; j < NC; j++) begin : g_cell
    cau_div_cell #(.W(W), .RW(RW), .K(NC - 1 - j)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl_in     (c_ch[j]),
      .pre_re_in  (pre_re[j]),
      .pre_im_in  (pre_im[j]),
      .r_re_in    (r_re[j]),
      .r_im_in    (r_im[j]),
      .q_re_in    (q_re[j]),
      .q_im_in    (q_im[j]),
      .d_in       (d_ch[j]),
      .ctl_out    (c_ch[j+1]),
      .pre_re_out (pre_re[j+1]),
      .pre_im_out (pre_im[j+1]),
      .r_re_out   (r_re[j+1]),
      .r_im_out   (r_im[j+1]),
      .q_re_out   (q_re[j+1]),
      .q_im_out   (q_im[j+1]),
      .d_out      (d_ch[j+1])
    );
  end

  // signed saturation of a quotient magnitude: {overflow, value}
  function automatic logic [W:0] quot_out(input logic [W+1:0] q, input logic neg);
    logic [W+1:0] half;
    half = (W+2)'(1) << (W - 1);
    if (q[W+1] || (neg ? (q > half) : (q >= half))) begin
      return neg ? {1'b1, 1'b1, {(W-1){1'b0}}} : {1'b1, 1'b0, {(W-1){1'b1}}};
    end
    return neg ? {1'b0, W'(-q)} : {1'b0, q[W-1:0]};
  endfunction

  cau_ctl_t     ce;
  logic [W:0]   qo_re, qo_im;
  logic [W-1:0] res_re_next, res_im_next;
  logic         ovf_next;

  always_comb begin
    ce          = c_ch[NC];
    qo_re       = quot_out(q_re[NC], ce.neg_re);
    qo_im       = quot_out(q_im[NC], ce.neg_im);
    res_re_next = pre_re[NC];
    res_im_next = pre_im[NC];
    ovf_next    = ce.ovf;
    if (ce.cmd == CMD_DIV) begin
      if (ce.dz) begin
        res_re_next = '0;
        res_im_next = '0;
        ovf_next    = 1'b0;
      end else begin
        res_re_next = qo_re[W-1:0];
        res_im_next = qo_im[W-1:0];
        ovf_next    = qo_re[W] | qo_im[W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ce.valid;
    end
    res_re   <= res_re_next;
    res_im   <= res_im_next;
    equal    <= ce.eq;
    div_zero <= ce.dz;
    overflow <= ovf_next;
  end

endmodule

// ----- rtl/cau_checker.sv -----
module cau_checker import cau_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  done,
  input logic [DATA_WIDTH-1:0] res_re,
  input logic [DATA_WIDTH-1:0] res_im,
  input logic                  equal,
  input logic                  div_zero,
  input logic                  overflow
);

  localparam logic [DATA_WIDTH-1:0] MAXV = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] MINV = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  a_eq_zero: assert property (@(posedge clk) disable iff (rst)
    done && equal |-> res_re == '0 && res_im == '0 && !overflow && !div_zero)
    else $error("equality item with nonzero parts or flags");

  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    done && div_zero |-> res_re == '0 && res_im == '0 && !overflow && !equal)
    else $error("zero divisor item with nonzero parts or flags");

  a_ovf_sat: assert property (@(posedge clk) disable iff (rst)
    done && overflow |->
      res_re == MAXV || res_re == MINV || res_im == MAXV || res_im == MINV)
    else $error("overflow without a saturated part");

  a_done_pulse_reset: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result strobe right after reset");

endmodule

bind complex_arithmetic_unit cau_checker #(.DATA_WIDTH(DATA_WIDTH)) u_cau_checker (
  .clk      (clk),
  .rst      (rst),
  .done     (done),
  .res_re   (res_re),
  .res_im   (res_im),
  .equal    (equal),
  .div_zero (div_zero),
  .overflow (overflow)
);

// ----- tb/sv/tb_top.sv -----
module tb_top;
  import cau_pkg::*;

  localparam int DW = 32;
  localparam int FB = 16;
  localparam int LATENCY = DW + 6;
  localparam int MAX_CYCLES = 200000;

  typedef struct {
    logic [2:0]        cmd;
    logic [DW-1:0]     a_re, a_im, b_re, b_im;
  } cx_op_t;

  typedef struct {
    logic [DW-1:0] re, im;
    logic          eq, dz, ovf;
  } cx_res_t;

  logic clk = 0, rst = 1;
  logic start = 0;
  logic busy;
  logic [2:0] cmd = '0;
  logic signed [DW-1:0] a_re = '0, a_im = '0, b_re = '0, b_im = '0;
  logic done;
  logic signed [DW-1:0] res_re, res_im;
  logic equal, div_zero, overflow;

  cx_op_t  pending_ops[$];
  cx_res_t expected_res[$];
  int      errors = 0;
  int      results_seen = 0;
  int      cycles = 0;
  int      gap = 0;
  bit      stim_done = 0;
  int      div_count = 0, sat_count = 0;

  complex_arithmetic_unit dut (
    .clk, .rst, .start, .busy, .cmd, .a_re, .a_im, .b_re, .b_im,
    .done, .res_re, .res_im, .equal, .div_zero, .overflow
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // clamp a wide signed value to the output range
  function automatic logic [DW-1:0] clamp_part(logic signed [159:0] v, ref logic ovf);
    logic signed [159:0] hi_lim, lo_lim;
    hi_lim = (160'sd1 <<< (DW - 1)) - 1;
    lo_lim = -(160'sd1 <<< (DW - 1));
    if (v > hi_lim) begin
      ovf = 1;
      return hi_lim[DW-1:0];
    end
    if (v < lo_lim) begin
      ovf = 1;
      return lo_lim[DW-1:0];
    end
    return v[DW-1:0];
  endfunction

  // quotient truncated toward zero, num scaled by 2^FB first
  function automatic logic signed [159:0] trunc_quot(logic signed [159:0] num,
                                                    logic [159:0] den);
    logic [159:0] mag;
    logic neg;
    neg = num < 0;
    mag = neg ? -num : num;
    mag = (mag << FB) / den;
    return neg ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic cx_res_t compute_complex(cx_op_t op);
    cx_res_t r;
    logic signed [159:0] ar, ai, br, bi, pre, pim, den;
    logic ovf;
    ar = $signed(op.a_re); ai = $signed(op.a_im);
    br = $signed(op.b_re); bi = $signed(op.b_im);
    r = '{default: '0};
    ovf = 0;
    case (op.cmd)
      CMD_ADD, CMD_SUB, CMD_MUL: begin
        if (op.cmd == CMD_ADD) begin
          pre = ar + br; pim = ai + bi;
        end else if (op.cmd == CMD_SUB) begin
          pre = ar - br; pim = ai - bi;
        end else begin
          pre = (ar * br - ai * bi) >>> FB;
          pim = (ar * bi + ai * br) >>> FB;
        end
        r.re = clamp_part(pre, ovf);
        r.im = clamp_part(pim, ovf);
      end
      CMD_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          r.dz = 1;
        end else begin
          r.re = clamp_part(trunc_quot(ar * br + ai * bi, den), ovf);
          r.im = clamp_part(trunc_quot(ai * br - ar * bi, den), ovf);
        end
      end
      CMD_EQ: r.eq = (op.a_re == op.b_re) && (op.a_im == op.b_im);
      default: ;
    endcase
    r.ovf = ovf;
    return r;
  endfunction

  function automatic logic [DW-1:0] rand_part();
    case ($urandom_range(0, 9))
      0: return {1'b1, {(DW-1){1'b0}}};
      1: return {1'b0, {(DW-1){1'b1}}};
      2: return '0;
      3: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hffff_0000;
      4, 5: return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic cx_op_t make_op(logic [2:0] c, logic [DW-1:0] w, logic [DW-1:0] x,
                                     logic [DW-1:0] y, logic [DW-1:0] z);
    cx_op_t op;
    op.cmd = c; op.a_re = w; op.a_im = x; op.b_re = y; op.b_im = z;
    return op;
  endfunction

  initial begin
    logic [DW-1:0] mx, mn;
    cx_op_t op;
    mx = {1'b0, {(DW-1){1'b1}}};
    mn = {1'b1, {(DW-1){1'b0}}};
    pending_ops.push_back(make_op(CMD_ADD, mx, mn, mx, mn));
    pending_ops.push_back(make_op(CMD_ADD, 32'h0001_8000, 32'hfffe_0000, 32'h0000_4000, 0));
    pending_ops.push_back(make_op(CMD_SUB, mn, mx, mx, mn));
    pending_ops.push_back(make_op(CMD_SUB, 32'h0003_0000, 1, 32'h0001_0000, 2));
    pending_ops.push_back(make_op(CMD_MUL, mx, mx, mx, mx));
    pending_ops.push_back(make_op(CMD_MUL, mn, mn, mn, mn));
    pending_ops.push_back(make_op(CMD_MUL, 32'hffff_ffff, 1, 1, 32'hffff_ffff));
    pending_ops.push_back(make_op(CMD_MUL, 32'h0002_0000, 32'h0003_0000,
                                  32'h0004_0000, 32'hffff_0000));
    pending_ops.push_back(make_op(CMD_DIV, 32'h0001_0000, 0, 0, 0));
    pending_ops.push_back(make_op(CMD_DIV, mx, mn, 0, 0));
    pending_ops.push_back(make_op(CMD_DIV, 32'h0006_0000, 32'h0002_0000,
                                  32'h0001_0000, 32'h0001_0000));
    pending_ops.push_back(make_op(CMD_DIV, mx, mx, 1, 0));
    pending_ops.push_back(make_op(CMD_DIV, mn, mn, mn, mn));
    pending_ops.push_back(make_op(CMD_DIV, 32'hffff_fffd, 7, 32'h0000_0002, 32'hffff_fffd));
    pending_ops.push_back(make_op(CMD_EQ, mx, mn, mx, mn));
    pending_ops.push_back(make_op(CMD_EQ, mx, mn, mx, mx));
    pending_ops.push_back(make_op(CMD_EQ, 0, 0, 0, 0));
    for (int c = 5; c < 8; c++)
      pending_ops.push_back(make_op(3'(c), mx, mn, 1, 2));
    for (int i = 0; i < 400; i++) begin
      op.cmd = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                            : 3'($urandom_range(0, 4));
      op.a_re = rand_part(); op.a_im = rand_part();
      op.b_re = rand_part(); op.b_im = rand_part();
      if (op.cmd == CMD_EQ && $urandom_range(0, 1)) begin
        op.b_re = op.a_re;
        if ($urandom_range(0, 2) != 0) op.b_im = op.a_im;
      end
      if (op.cmd == CMD_DIV && $urandom_range(0, 9) == 0) begin
        op.b_re = 0; op.b_im = 0;
      end
      pending_ops.push_back(op);
    end
  end

  // drive on the falling edge, one item per accepting rising edge
  always @(negedge clk) begin
    cx_op_t op;
    if (rst) begin
      start <= 0;
    end else if (start && busy) begin
      // hold the current item
    end else if (gap > 0) begin
      gap <= gap - 1;
      start <= 0;
    end else if (pending_ops.size() > 0) begin
      op = pending_ops.pop_front();
      start <= 1;
      cmd <= op.cmd; a_re <= op.a_re; a_im <= op.a_im; b_re <= op.b_re; b_im <= op.b_im;
      case ($urandom_range(0, 9))
        0, 1, 2: gap <= $urandom_range(1, 3);
        3: gap <= $urandom_range(10, 60);
        default: gap <= 0;
      endcase
    end else begin
      start <= 0;
      stim_done <= 1;
    end
  end

  always @(posedge clk) begin
    cx_op_t op;
    cx_res_t exp_r;
    cycles <= cycles + 1;
    if (!rst && start && !busy) begin
      op.cmd = cmd; op.a_re = a_re; op.a_im = a_im; op.b_re = b_re; op.b_im = b_im;
      exp_r = compute_complex(op);
      if (op.cmd == CMD_DIV) div_count <= div_count + 1;
      if (exp_r.ovf) sat_count <= sat_count + 1;
      expected_res.push_back(exp_r);
    end
    if (!rst && done) begin
      results_seen <= results_seen + 1;
      if (expected_res.size() == 0) begin
        $error("result with nothing expected");
        errors = errors + 1;
      end else begin
        exp_r = expected_res.pop_front();
        if (res_re !== exp_r.re) begin
          $error("res_re exp %h got %h", exp_r.re, res_re); errors = errors + 1;
        end
        if (res_im !== exp_r.im) begin
          $error("res_im exp %h got %h", exp_r.im, res_im); errors = errors + 1;
        end
        if (equal !== exp_r.eq) begin
          $error("equal exp %b got %b", exp_r.eq, equal); errors = errors + 1;
        end
        if (div_zero !== exp_r.dz) begin
          $error("div_zero exp %b got %b", exp_r.dz, div_zero); errors = errors + 1;
        end
        if (overflow !== exp_r.ovf) begin
          $error("overflow exp %b got %b", exp_r.ovf, overflow); errors = errors + 1;
        end
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk) rst = 0;
    wait (stim_done && expected_res.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    #1;
    $display("covered %0d results, %0d divides, %0d saturated", results_seen, div_count,
             sat_count);
    if (errors == 0 && expected_res.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  initial begin
    wait (cycles >= MAX_CYCLES);
    $display("timeout, %0d still expected", expected_res.size());
    $display("tb: failure");
    $finish;
  end
endmodule

// ----- complex_arithmetic_unit.f -----
rtl/cau_pkg.sv
rtl/cau_front.sv
rtl/cau_div_cell.sv
rtl/complex_arithmetic_unit.sv
rtl/cau_checker.sv
tb/sv/tb_top.sv
